// File: src/ipv4_pkg.sv
// ----------------------------------------------------------------------------
// ipv4_pkg: shared types and constants for the dotted address parser
// Parse phases, part radix codes and the character codes the parser tests.
// ----------------------------------------------------------------------------
package ipv4_pkg;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_ZERO   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_ERROR  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_e;

  localparam int unsigned MaxParts = 4;
  localparam logic [1:0] LastPartIdx = 2'(MaxParts - 1);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;

endpackage

// File: src/ipv4_dotted_address_parser.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_address_parser: streaming textual IPv4 address parser
// Takes one ASCII character per transaction and reports the parsed address
// when the terminating NUL arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / ch_i) carries one character per
//   transaction, text in the a, a.b, a.b.c or a.b.c.d form; each part is
//   decimal, octal (leading 0) or hex (leading 0x). A NUL character ends the
//   string. Only the NUL transaction produces a result, on the output channel
//   (out_valid_o / out_stall_i / valid_res_o / address_o); address_o is zero
//   when valid_res_o is low.
//   Every character is handled by the digit/dot decode and the shift-add
//   accumulator, so one character is taken per clock while in_stall_o is low.
//   The result is held in an output register and shows up the cycle after
//   the NUL is accepted.
//   While a result waits and out_stall_i is high, in_stall_o is raised; with
//   the output register free or being drained the input is never stalled.
//   Reset clears the parse state and the output valid flag, not the result
//   payload; the block takes characters from the first cycle after reset.
// ----------------------------------------------------------------------------
module ipv4_dotted_address_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        valid_res_o,
  output logic [31:0] address_o
);

  ipv4_pkg::phase_e phase_q, phase_d;
  ipv4_pkg::radix_e radix_q, radix_d;
  logic [31:0] accum_q, accum_d;
  logic        ovf_q, ovf_d;
  logic [1:0]  part_cnt_q, part_cnt_d;
  logic [7:0]  part0_q;
  logic [15:0] part1_q;
  logic [23:0] part2_q;
  logic        out_valid_q, out_valid_d;
  logic        valid_res_q, valid_res_d;
  logic [31:0] address_q, address_d;

  logic        in_acc;
  logic        is_nul;
  logic        is_dec;
  logic        is_hex_alpha;
  logic        is_space;
  logic        is_x;
  logic        is_dot;
  logic [3:0]  digit;
  logic [35:0] prod;
  logic [35:0] sum;
  logic        fin_ok;
  logic [31:0] fin_addr;
  logic        part_wr;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_nul     = (ch_i == ipv4_pkg::ChNul);

  // character classes
  always_comb begin
    is_dec       = (ch_i >= ipv4_pkg::ChZero) && (ch_i <= ipv4_pkg::ChNine);
    is_space     = (ch_i == ipv4_pkg::ChSpace) ||
                   ((ch_i >= ipv4_pkg::ChTab) && (ch_i <= ipv4_pkg::ChCr));
    is_x         = (ch_i == ipv4_pkg::ChLowX) || (ch_i == ipv4_pkg::ChUpX);
    is_dot       = (ch_i == ipv4_pkg::ChDot);
    is_hex_alpha = 1'b0;
    digit        = 4'(ch_i - ipv4_pkg::ChZero);
    if ((ch_i >= ipv4_pkg::ChLowA) && (ch_i <= ipv4_pkg::ChLowF)) begin
      is_hex_alpha = 1'b1;
      digit        = 4'(ch_i - ipv4_pkg::ChLowA + 8'd10);
    end else if ((ch_i >= ipv4_pkg::ChUpA) && (ch_i <= ipv4_pkg::ChUpF)) begin
      is_hex_alpha = 1'b1;
      digit        = 4'(ch_i - ipv4_pkg::ChUpA + 8'd10);
    end
  end

  // accumulator times radix plus digit
  always_comb begin
    case (radix_q)
      ipv4_pkg::RX_HEX: prod = {accum_q, 4'b0};
      ipv4_pkg::RX_OCT: prod = {1'b0, accum_q, 3'b0};
      default:          prod = {1'b0, accum_q, 3'b0} + {3'b0, accum_q, 1'b0};
    endcase
    sum = prod + 36'(digit);
  end

  // address assembly at end of string
  always_comb begin
    fin_ok   = 1'b0;
    fin_addr = '0;
    if ((phase_q == ipv4_pkg::PH_ZERO) || (phase_q == ipv4_pkg::PH_DIGITS) ||
        (phase_q == ipv4_pkg::PH_TRAIL)) begin
      case (part_cnt_q)
        2'd0: begin
          fin_ok   = 1'b1;
          fin_addr = accum_q;
        end
        2'd1: begin
          fin_ok   = ~ovf_q && (accum_q[31:24] == '0);
          fin_addr = accum_q | {part0_q, 24'b0};
        end
        2'd2: begin
          fin_ok   = ~ovf_q && (accum_q[31:16] == '0);
          fin_addr = accum_q | {part0_q, 24'b0} | {part1_q, 16'b0};
        end
        default: begin
          fin_ok   = ~ovf_q && (accum_q[31:8] == '0);
          fin_addr = accum_q | {part0_q, 24'b0} | {part1_q, 16'b0}
                     | {part2_q, 8'b0};
        end
      endcase
    end
    if (!fin_ok) begin
      fin_addr = '0;
    end
  end

  // parse state update
  always_comb begin
    phase_d    = phase_q;
    radix_d    = radix_q;
    accum_d    = accum_q;
    ovf_d      = ovf_q;
    part_cnt_d = part_cnt_q;
    part_wr    = 1'b0;
    if (in_acc) begin
      if (is_nul) begin
        phase_d    = ipv4_pkg::PH_START;
        radix_d    = ipv4_pkg::RX_DEC;
        accum_d    = '0;
        ovf_d      = 1'b0;
        part_cnt_d = '0;
      end else begin
        unique case (phase_q)
          ipv4_pkg::PH_START: begin
            if (!is_dec) begin
              phase_d = ipv4_pkg::PH_ERROR;
            end else begin
              ovf_d = 1'b0;
              if (ch_i == ipv4_pkg::ChZero) begin
                radix_d = ipv4_pkg::RX_OCT;
                accum_d = '0;
                phase_d = ipv4_pkg::PH_ZERO;
              end else begin
                radix_d = ipv4_pkg::RX_DEC;
                accum_d = 32'(digit);
                phase_d = ipv4_pkg::PH_DIGITS;
              end
            end
          end
          ipv4_pkg::PH_ZERO, ipv4_pkg::PH_DIGITS: begin
            phase_d = ipv4_pkg::PH_DIGITS;
            if ((phase_q == ipv4_pkg::PH_ZERO) && is_x) begin
              radix_d = ipv4_pkg::RX_HEX;
            end else if (is_dec || (is_hex_alpha && (radix_q == ipv4_pkg::RX_HEX))) begin
              accum_d = sum[31:0];
              ovf_d   = ovf_q | (sum[35:32] != '0);
            end else if (is_dot) begin
              if (part_cnt_q >= ipv4_pkg::LastPartIdx) begin
                phase_d = ipv4_pkg::PH_ERROR;
              end else begin
                part_wr    = 1'b1;
                part_cnt_d = part_cnt_q + 2'd1;
                phase_d    = ipv4_pkg::PH_START;
              end
            end else if (is_space) begin
              phase_d = ipv4_pkg::PH_TRAIL;
            end else begin
              phase_d = ipv4_pkg::PH_ERROR;
            end
          end
          ipv4_pkg::PH_TRAIL: begin
            phase_d = ipv4_pkg::PH_TRAIL;
          end
          default: begin
            phase_d = ipv4_pkg::PH_ERROR;
          end
        endcase
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    valid_res_d = valid_res_q;
    address_d   = address_q;
    if (in_acc && is_nul) begin
      out_valid_d = 1'b1;
      valid_res_d = fin_ok;
      address_d   = fin_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ipv4_pkg::PH_START;
      radix_q     <= ipv4_pkg::RX_DEC;
      accum_q     <= '0;
      ovf_q       <= 1'b0;
      part_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      radix_q     <= radix_d;
      accum_q     <= accum_d;
      ovf_q       <= ovf_d;
      part_cnt_q  <= part_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // earlier parts and result payload
  always_ff @(posedge clk_i) begin
    valid_res_q <= valid_res_d;
    address_q   <= address_d;
    if (part_wr) begin
      case (part_cnt_q)
        2'd0:    part0_q <= accum_q[7:0];
        2'd1:    part1_q <= accum_q[15:0];
        default: part2_q <= accum_q[23:0];
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = valid_res_q;
  assign address_o   = address_q;

`ifndef SYNTHESIS
  a_rise_after_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_i && !in_stall_o && (ch_i == ipv4_pkg::ChNul)))
    else $error("result without end of string");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (address_o == '0))
    else $error("invalid result with nonzero address");

  a_nul_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_nul) |=> ((phase_q == ipv4_pkg::PH_START) && (part_cnt_q == '0)
                            && (accum_q == '0) && !ovf_q))
    else $error("state not cleared after end of string");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == ipv4_pkg::PH_ERROR) && !(in_acc && is_nul)) |=>
      (phase_q == ipv4_pkg::PH_ERROR))
    else $error("error phase left before end of string");
`endif

endmodule
